// ===== rtl/lrws_pkg.sv =====
// Shared types and constants for the lattice random walk sweep unit.
`default_nettype none
package lrws_pkg;

  localparam int SEED_W     = 31;
  localparam int WALK_W     = 11;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int PM_A_W     = 15;

  typedef logic [SEED_W-1:0]     lcg_t;
  typedef logic [WALK_W-1:0]     walk_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [1:0]            dir_t;

  localparam cfg_idx_t CFG_SEED    = 2'd0;
  localparam cfg_idx_t CFG_WALKERS = 2'd1;

  localparam dir_t DIR_XP = 2'd0;
  localparam dir_t DIR_XN = 2'd1;
  localparam dir_t DIR_YP = 2'd2;
  localparam dir_t DIR_YN = 2'd3;

  localparam logic [PM_A_W-1:0] PM_A      = 15'd16807;
  localparam lcg_t              PM_M      = 31'h7FFF_FFFF;
  localparam logic [32:0]       PM_M_X1   = 33'd2147483647;
  localparam logic [32:0]       PM_M_X2   = 33'd4294967294;
  localparam logic [32:0]       PM_M_X3   = 33'd6442450941;
  localparam count_t            COUNT_MAX = 11'd2047;
  localparam lcg_t              SEED_RST  = 31'd1;
  localparam walk_t             WALK_RST  = 11'd1024;

endpackage
`default_nettype wire

// ===== rtl/lrws_if.sv =====
// Valid/ready channel interfaces for sweep commands, results and configuration.
`default_nettype none
interface lrws_cmd_if;
  import lrws_pkg::*;
  logic valid;
  logic ready;
  logic clear;
  modport source (output valid, output clear, input ready);
  modport sink (input valid, input clear, output ready);
endinterface

interface lrws_res_if;
  import lrws_pkg::*;
  logic   valid;
  logic   ready;
  count_t origin_count;
  lcg_t   generator_value;
  modport source (output valid, output origin_count, output generator_value, input ready);
  modport sink (input valid, input origin_count, input generator_value, output ready);
endinterface

interface lrws_cfg_if;
  import lrws_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrws_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module lrws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lattice_random_walk_sweep_unit.sv =====
// Top level: sweeps of 2D lattice random walkers driven by a minimal-standard generator.
//
// Channels: cmd (sink) carries one sweep request with a clear flag; res (source)
// returns the number of stepped walkers standing at the origin and the
// generator value after the sweep; cfg (sink, always ready) writes the seed
// (index 0) and the active walker count (index 1); the user must write them
// only while the unit is idle, as the block itself does not enforce it.
// Each walker passes through a READ state, which multiplies the generator
// value by 16807 while its position is read, and then an UPDATE state, which
// folds the product modulo 2^31-1 and writes the new position. That
// multiply-and-fold loop sets the rate. A sweep holds cmd.ready low until the
// unit returns to idle; a clear sweep first zeroes the position memory.
// After reset the position memory is zeroed in a clearing pass with
// cmd.ready low; cfg writes are taken throughout. A stalled res holds its
// result in the output register; the next cmd is taken meanwhile and its
// sweep runs, then waits until the output register frees up.
`default_nettype none
module lattice_random_walk_sweep_unit #(
  parameter int NUM_WALKERS = 1024,
  parameter int POS_WIDTH   = 16
) (
  input wire logic clk,
  input wire logic rst,
  lrws_cmd_if.sink   cmd,
  lrws_res_if.source res,
  lrws_cfg_if.sink   cfg
);
  import lrws_pkg::*;

  localparam int IDX_W  = (NUM_WALKERS > 1) ? $clog2(NUM_WALKERS) : 1;
  localparam int NW_W   = $clog2(NUM_WALKERS + 1);
  localparam int PROD_W = SEED_W + PM_A_W;
  localparam int MEM_W  = 2 * POS_WIDTH;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WALKERS - 1);
  localparam logic [NW_W-1:0]  NW_MAX   = NW_W'(NUM_WALKERS);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-2){1'b0}}, 1'b1};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state;
  logic              pending;
  logic [IDX_W-1:0]  idx;
  logic [NW_W-1:0]   nwalk;
  logic [NW_W-1:0]   nwalk_next;
  count_t            count;
  lcg_t              lcg;
  lcg_t              lcg_next;
  lcg_t              seed;
  lcg_t              seed_ok;
  walk_t             walkers;
  logic [PROD_W-1:0] prod;
  dir_t              dir;
  dir_t              dir_next;
  logic [32:0]       v4;
  logic [31:0]       fold_sum;

  logic                 res_valid;
  count_t               res_count;
  lcg_t                 res_value;
  logic                 out_free;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [MEM_W-1:0]     ram_wdata;
  logic [MEM_W-1:0]     ram_rdata;

  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] new_x;
  logic signed [POS_WIDTH-1:0] new_y;

  logic cmd_xfer;
  logic at_last;

  lrws_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_WALKERS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign cmd.ready           = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign res.valid           = res_valid;
  assign res.origin_count    = res_count;
  assign res.generator_value = res_value;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign out_free = !res_valid || res.ready;
  assign at_last  = (NW_W'(idx) == nwalk - NW_W'(1));
  assign seed_ok  = ((seed == '0) || (seed == PM_M)) ? SEED_RST : seed;

  always_comb begin
    if (32'(walkers) > 32'(NUM_WALKERS)) begin
      nwalk_next = NW_MAX;
    end else begin
      nwalk_next = NW_W'(walkers);
    end
  end

  // step choice from the current generator value
  always_comb begin
    v4 = {lcg, 2'b00};
    if (v4 <= PM_M_X1) begin
      dir_next = DIR_XP;
    end else if (v4 <= PM_M_X2) begin
      dir_next = DIR_XN;
    end else if (v4 <= PM_M_X3) begin
      dir_next = DIR_YP;
    end else begin
      dir_next = DIR_YN;
    end
  end

  // product mod 2^31-1: add the high part to the low 31 bits, subtract once
  always_comb begin
    fold_sum = {1'b0, prod[SEED_W-1:0]} + 32'(prod[PROD_W-1:SEED_W]);
    if (fold_sum >= {1'b0, PM_M}) begin
      lcg_next = SEED_W'(fold_sum - {1'b0, PM_M});
    end else begin
      lcg_next = fold_sum[SEED_W-1:0];
    end
  end

  always_comb begin
    pos_x = ram_rdata[MEM_W-1:POS_WIDTH];
    pos_y = ram_rdata[POS_WIDTH-1:0];
    new_x = pos_x;
    new_y = pos_y;
    case (dir)
      DIR_XP: begin
        if (pos_x != POS_MAX) new_x = pos_x + POS_WIDTH'(1);
      end
      DIR_XN: begin
        if (pos_x != POS_MIN) new_x = pos_x - POS_WIDTH'(1);
      end
      DIR_YP: begin
        if (pos_y != POS_MAX) new_y = pos_y + POS_WIDTH'(1);
      end
      DIR_YN: begin
        if (pos_y != POS_MIN) new_y = pos_y - POS_WIDTH'(1);
      end
      default: begin
        new_x = pos_x;
      end
    endcase
  end

  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_UPDATE);
    ram_waddr = idx;
    if (state == ST_CLEAR) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {new_x, new_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= SEED_RST;
      walkers <= WALK_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SEED:    seed    <= cfg.data[SEED_W-1:0];
        CFG_WALKERS: walkers <= cfg.data[WALK_W-1:0];
        default:     seed    <= seed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pending   <= 1'b0;
      idx       <= '0;
      lcg       <= SEED_RST;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            nwalk <= nwalk_next;
            count <= '0;
            idx   <= '0;
            if (cmd.clear) begin
              lcg     <= seed_ok;
              pending <= 1'b1;
              state   <= ST_CLEAR;
            end else if (nwalk_next == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_CLEAR: begin
          if (idx == IDX_LAST) begin
            idx     <= '0;
            pending <= 1'b0;
            if (!pending) begin
              state <= ST_IDLE;
            end else if (nwalk == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_READ;
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_READ: begin
          prod  <= lcg * PM_A;
          dir   <= dir_next;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          lcg <= lcg_next;
          if ((new_x == '0) && (new_y == '0) && (count != COUNT_MAX)) begin
            count <= count + COUNT_W'(1);
          end
          if (at_last) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res_count <= count;
            res_value <= lcg;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_clear_starts_pass: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && cmd.clear) |=> (state == ST_CLEAR))
    else $error("clear transfer did not start the clearing pass");

  a_lcg_in_range: assert property (@(posedge clk) disable iff (rst)
    (lcg != '0) && (lcg != PM_M))
    else $error("generator left its valid range");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (32'(count) <= 32'(idx)))
    else $error("origin count exceeds walkers stepped");

  a_read_then_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_UPDATE))
    else $error("read phase not followed by update");

endmodule
`default_nettype wire

// ===== verif/tb_lattice_random_walk_sweep_unit.sv =====
// Self-checking testbench for the lattice random walk sweep unit.
module tb_lattice_random_walk_sweep_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lrws_pkg::*;

  localparam int NUM_WALKERS = 1024;
  localparam int POS_WIDTH = 16;
  localparam int POS_LIMIT = (1 << (POS_WIDTH - 1)) - 1;
  localparam longint unsigned MODULUS = 64'd2147483647;
  localparam longint unsigned MULTIPLIER = 64'd16807;
  localparam int RANDOM_SWEEPS = 430;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3200;
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  typedef struct {
    count_t origin_count;
    lcg_t generator_value;
  } sweep_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cmd_valid = 1'b0;
  logic cmd_clear = 1'b0;
  logic res_ready = 1'b0;
  logic cfg_valid = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_data = '0;

  lrws_cmd_if cmd_ch();
  lrws_res_if res_ch();
  lrws_cfg_if cfg_ch();

  assign cmd_ch.valid = cmd_valid;
  assign cmd_ch.clear = cmd_clear;
  assign res_ch.ready = res_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data = cfg_data;

  lattice_random_walk_sweep_unit #(
    .NUM_WALKERS(NUM_WALKERS),
    .POS_WIDTH(POS_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // walker state and registers as the unit should hold them
  pos_t x_pos [NUM_WALKERS];
  pos_t y_pos [NUM_WALKERS];
  lcg_t gen_state;
  lcg_t seed_reg;
  walk_t walker_reg;

  bit sweep_plan[$];
  sweep_result_t awaited[$];

  int sent_count = 0;
  int taken_count = 0;
  int clears_taken = 0;
  int results_seen = 0;
  int origin_hits = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;

  function automatic pos_t nudge(input pos_t p, input int delta);
    int moved_to;
    moved_to = int'(p) + delta;
    if (moved_to > POS_LIMIT) moved_to = POS_LIMIT;
    if (moved_to < -POS_LIMIT) moved_to = -POS_LIMIT;
    return pos_t'(moved_to);
  endfunction

  function automatic void walk_sweep(input bit do_clear);
    int n;
    int cnt;
    longint unsigned quad;
    longint unsigned prod;
    dir_t d;
    sweep_result_t r;
    if (do_clear) begin
      x_pos = '{default: '0};
      y_pos = '{default: '0};
      gen_state = (seed_reg == 31'd0 || seed_reg == 31'h7FFF_FFFF) ? 31'd1 : seed_reg;
    end
    n = (int'(walker_reg) > NUM_WALKERS) ? NUM_WALKERS : int'(walker_reg);
    cnt = 0;
    for (int k = 0; k < n; k++) begin
      quad = gen_state;
      quad = quad << 2;
      if (quad <= MODULUS) d = DIR_XP;
      else if (quad <= 2 * MODULUS) d = DIR_XN;
      else if (quad <= 3 * MODULUS) d = DIR_YP;
      else d = DIR_YN;
      case (d)
        DIR_XP: x_pos[k] = nudge(x_pos[k], 1);
        DIR_XN: x_pos[k] = nudge(x_pos[k], -1);
        DIR_YP: y_pos[k] = nudge(y_pos[k], 1);
        default: y_pos[k] = nudge(y_pos[k], -1);
      endcase
      if (x_pos[k] == 0 && y_pos[k] == 0 && cnt < int'(COUNT_MAX)) cnt++;
      prod = gen_state;
      prod = (prod * MULTIPLIER) % MODULUS;
      gen_state = lcg_t'(prod);
    end
    r.origin_count = count_t'(cnt);
    r.generator_value = gen_state;
    awaited.push_back(r);
  endfunction

  // sweep command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (sent_count == taken_count) begin
      if (gap_left == 0 && sent_count < sweep_plan.size()) begin
        cmd_valid <= 1'b1;
        cmd_clear <= sweep_plan[sent_count];
        sent_count++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        cmd_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (res_ready) begin
      res_ready <= 1'b0;
      hold_left = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 2500)
                                                : $urandom_range(0, 7);
    end else begin
      res_ready <= 1'b1;
      hold_left = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 3000)
                                               : $urandom_range(0, 30);
    end
  end

  // transfer monitor, prediction, checking and watchdog
  always @(posedge clk) begin
    bit busy_edge;
    sweep_result_t want;
    busy_edge = 1'b0;
    if (rst) begin
      seed_reg = 31'd1;
      walker_reg = 11'd1024;
      gen_state = 31'd1;
      x_pos = '{default: '0};
      y_pos = '{default: '0};
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ch.ready) begin
        busy_edge = 1'b1;
        reg_writes++;
        case (cfg_index)
          CFG_SEED: seed_reg = cfg_data;
          CFG_WALKERS: walker_reg = cfg_data[WALK_W-1:0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ready) begin
        busy_edge = 1'b1;
        if (awaited.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d with no sweep outstanding: origin_count %0d generator_value %0d",
                     results_seen, res_ch.origin_count, res_ch.generator_value);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (want.origin_count != 0) origin_hits++;
          if (res_ch.origin_count !== want.origin_count ||
              res_ch.generator_value !== want.generator_value) begin
            if (mismatches < 10)
              $display("result %0d: origin_count exp %0d got %0d, generator_value exp %0d got %0d",
                       results_seen, want.origin_count, res_ch.origin_count,
                       want.generator_value, res_ch.generator_value);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (cmd_valid && cmd_ch.ready) begin
        busy_edge = 1'b1;
        walk_sweep(cmd_clear);
        if (cmd_clear) clears_taken++;
        taken_count++;
      end
      if (busy_edge) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic put_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input cfg_data_t sd, input int wk);
    cfg_data_t wdata;
    wdata = cfg_data_t'({20'($urandom_range(0, 1048575)), 11'(wk)});
    if ($urandom_range(0, 1) == 1) begin
      put_reg(CFG_SEED, sd);
      put_reg(CFG_WALKERS, wdata);
    end else begin
      put_reg(CFG_WALKERS, wdata);
      put_reg(CFG_SEED, sd);
    end
  endtask

  task automatic settle();
    while (taken_count != sweep_plan.size() || awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cfg_data_t turn_seeds [6];
    cfg_data_t sd;
    int total;
    int len;
    int wk;
    turn_seeds = '{31'd536870911, 31'd536870912, 31'd1073741823,
                   31'd1073741824, 31'd1610612735, 31'd1610612736};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: full walker set from the reset generator value
    sweep_plan.push_back(1'b0);
    sweep_plan.push_back(1'b1);
    settle();

    program_regs(31'd2147483646, 1);
    sweep_plan.push_back(1'b1);
    repeat (3) sweep_plan.push_back(1'b0);
    settle();

    // zero walkers and a seed that must fall back to one
    program_regs(31'd0, 0);
    sweep_plan.push_back(1'b1);
    sweep_plan.push_back(1'b0);
    settle();

    // walker count beyond the array, all-ones seed
    program_regs(31'h7FFF_FFFF, 2047);
    sweep_plan.push_back(1'b1);
    sweep_plan.push_back(1'b0);
    settle();

    // seeds on either side of each direction threshold
    for (int k = 0; k < 6; k++) begin
      program_regs(turn_seeds[k], 1);
      sweep_plan.push_back(1'b1);
      settle();
    end

    put_reg(CFG_SPARE, '1);
    program_regs(cfg_data_t'($urandom_range(1, 32'd2147483646)), 2);
    sweep_plan.push_back(1'b1);
    repeat (5) sweep_plan.push_back(1'b0);
    settle();

    total = 0;
    while (total < RANDOM_SWEEPS) begin
      case ($urandom_range(0, 19))
        0: wk = 0;
        1: wk = NUM_WALKERS;
        2: wk = $urandom_range(NUM_WALKERS + 1, 2047);
        3, 4: wk = $urandom_range(13, 100);
        default: wk = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: sd = 31'd0;
          1: sd = 31'd1;
          2: sd = 31'd2147483646;
          default: sd = 31'h7FFF_FFFF;
        endcase
      end else begin
        sd = cfg_data_t'($urandom_range(1, 32'd2147483646));
      end
      if ($urandom_range(0, 5) == 0) put_reg(CFG_SPARE, cfg_data_t'($urandom));
      program_regs(sd, wk);
      len = (wk > 100) ? $urandom_range(3, 6) : $urandom_range(30, 70);
      for (int k = 0; k < len; k++)
        sweep_plan.push_back((k == 0 && $urandom_range(0, 3) != 0) ||
                             $urandom_range(0, 11) == 0);
      total += len;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d sweeps run (%0d starting from a clear), %0d results compared",
             taken_count, clears_taken, results_seen);
    $display("%0d register writes; %0d sweeps left walkers at the origin",
             reg_writes, origin_hits);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, awaited.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== lattice_random_walk_sweep_unit.f =====
rtl/lrws_pkg.sv
rtl/lrws_if.sv
rtl/lrws_ram.sv
rtl/lattice_random_walk_sweep_unit.sv
verif/tb_lattice_random_walk_sweep_unit.sv
